// ===== rtl/min_time_trapezoid_profile_core_assert.svh =====
// assertion macros for the trapezoid profile core
// expects clk and rst_n in the scope of use
`ifndef MIN_TIME_TRAPEZOID_PROFILE_CORE_ASSERT_SVH
`define MIN_TIME_TRAPEZOID_PROFILE_CORE_ASSERT_SVH

// same-cycle implication
`define MTTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mttp_pkg.sv =====
// shared constants, codes and types of the trapezoid profile core
// no dependencies
package mttp_pkg;

  localparam int VW        = 32;
  localparam int FB        = 16;
  localparam int PW        = 2 * VW;
  localparam int MW        = 2 * (VW - 1);
  localparam int SQ_STEPS  = VW;
  localparam int DIV_STEPS = VW;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_VLIM   = 2'd1;
  localparam logic [1:0] ST_NONPOS = 2'd2;
  localparam logic [1:0] ST_IMPOSS = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_PEAK   = 2'd1;
  localparam logic [1:0] KIND_CRUISE = 2'd2;

  localparam logic [1:0] REG_FLOOR = 2'd0;
  localparam logic [1:0] REG_CEIL  = 2'd1;
  localparam logic [1:0] REG_ACCEL = 2'd2;

  typedef logic [VW-1:0] word_t;
  typedef logic [VW-2:0] mag_t;
  typedef logic [PW-1:0] dword_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] kind;
    mag_t       u0;
    mag_t       uf;
    mag_t       um;
    mag_t       ua;
    mag_t       vel;
    dword_t     twoda;
    dword_t     need;
    dword_t     den3;
  } ctx_t;

endpackage

// ===== rtl/mttp_in_if.sv =====
// move request channel of the trapezoid profile core
// uses mttp_pkg
interface mttp_in_if;
  logic           valid;
  logic           ready;
  mttp_pkg::word_t distance;
  mttp_pkg::word_t start_velocity;
  mttp_pkg::word_t end_velocity;

  modport source (output valid, output distance, output start_velocity,
                  output end_velocity, input ready);
  modport sink (input valid, input distance, input start_velocity,
                input end_velocity, output ready);
endinterface

// ===== rtl/mttp_out_if.sv =====
// result channel of the trapezoid profile core
// uses mttp_pkg
interface mttp_out_if;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [1:0]      profile_kind;
  mttp_pkg::word_t time_accel_end;
  mttp_pkg::word_t time_decel_start;
  mttp_pkg::word_t time_move_end;
  mttp_pkg::mag_t  profile_velocity;

  modport source (output valid, output status, output profile_kind,
                  output time_accel_end, output time_decel_start,
                  output time_move_end, output profile_velocity, input ready);
  modport sink (input valid, input status, input profile_kind,
                input time_accel_end, input time_decel_start,
                input time_move_end, input profile_velocity, output ready);
endinterface

// ===== rtl/mttp_cfg_if.sv =====
// register write channel of the trapezoid profile core
// uses mttp_pkg
interface mttp_cfg_if;
  logic            valid;
  logic            ready;
  logic [1:0]      index;
  mttp_pkg::word_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mttp_fixdiv.sv =====
// pipelined fixed-point divider: floor(num * 2^FB / den), saturating
// one restoring step per stage; uses mttp_pkg
module mttp_fixdiv (
  input  logic             clk,
  input  logic             en,
  input  mttp_pkg::dword_t num,
  input  mttp_pkg::dword_t den,
  output mttp_pkg::word_t  quo
);

  localparam int N  = mttp_pkg::DIV_STEPS;
  localparam int VW = mttp_pkg::VW;
  localparam int PW = mttp_pkg::PW;
  localparam int SH = mttp_pkg::VW - mttp_pkg::FB;

  mttp_pkg::dword_t r_r   [0:N];
  mttp_pkg::dword_t d_r   [0:N];
  mttp_pkg::word_t  x_r   [0:N];
  mttp_pkg::word_t  q_r   [0:N];
  logic             sat_r [0:N];

  mttp_pkg::dword_t num_sh;
  assign num_sh = num << mttp_pkg::FB;

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= ({{SH{1'b0}}, num} >= {den, {SH{1'b0}}});
      r_r[0]   <= num >> SH;
      x_r[0]   <= num_sh[VW-1:0];
      d_r[0]   <= den;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [PW:0] sh;
    logic        ge;
    logic [PW:0] diff;
    assign sh   = {r_r[k], x_r[k][VW-1-k]};
    assign ge   = sh >= {1'b0, d_r[k]};
    assign diff = sh - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= ge ? diff[PW-1:0] : sh[PW-1:0];
        d_r[k+1]   <= d_r[k];
        x_r[k+1]   <= x_r[k];
        q_r[k+1]   <= {q_r[k][VW-2:0], ge};
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign quo = sat_r[N] ? '1 : q_r[N];

endmodule

// ===== rtl/min_time_trapezoid_profile_core.sv =====
// top level of the minimum-time trapezoid profile planner
// uses mttp_pkg, the three channel interfaces, mttp_fixdiv and the assertion header
// Takes one move request per clock while the pipe is not stalled and returns one result per
// request, in order. The peak velocity square root runs one bit per stage over 32 stages,
// then three 33-stage restoring dividers work side by side. The whole pipe advances when
// the output register is empty or taken; in_if.ready follows that. The user must write
// registers only while no request is in flight; the block itself does not enforce this.
`include "min_time_trapezoid_profile_core_assert.svh"

module min_time_trapezoid_profile_core (
  input  logic        clk,
  input  logic        rst_n,
  mttp_in_if.sink     in_if,
  mttp_out_if.source  out_if,
  mttp_cfg_if.sink    cfg_if
);

  localparam int VW = mttp_pkg::VW;
  localparam int PW = mttp_pkg::PW;
  localparam int MW = mttp_pkg::MW;
  localparam int SQ = mttp_pkg::SQ_STEPS;
  localparam int DL = mttp_pkg::DIV_LAT;

  // configuration registers
  logic signed [VW-1:0] floor_r, ceil_r, accel_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
      ceil_r  <= VW'(65536);
      accel_r <= VW'(65536);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        mttp_pkg::REG_FLOOR: floor_r <= $signed(cfg_if.data);
        mttp_pkg::REG_CEIL:  ceil_r  <= $signed(cfg_if.data);
        mttp_pkg::REG_ACCEL: accel_r <= $signed(cfg_if.data);
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // stage 0: input capture
  logic                 s0_v_r;
  logic signed [VW-1:0] s0_d_r, s0_v0_r, s0_vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (en) s0_v_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r  <= $signed(in_if.distance);
      s0_v0_r <= $signed(in_if.start_velocity);
      s0_vf_r <= $signed(in_if.end_velocity);
    end
  end

  // stage 1: limit checks and products
  logic            lim_err, np_err;
  logic [MW-1:0]   p_da, p_00, p_ff, p_mm, p_am;
  mttp_pkg::mag_t  ud, u0, uf, um, ua;

  assign lim_err = (floor_r < 0) || (ceil_r <= floor_r) ||
                   (s0_v0_r < floor_r) || (s0_v0_r > ceil_r) ||
                   (s0_vf_r < floor_r) || (s0_vf_r > ceil_r);
  assign np_err  = (s0_d_r <= 0) || (accel_r <= 0);
  assign ud = s0_d_r[VW-2:0];
  assign u0 = s0_v0_r[VW-2:0];
  assign uf = s0_vf_r[VW-2:0];
  assign um = ceil_r[VW-2:0];
  assign ua = accel_r[VW-2:0];
  assign p_da = MW'(ud) * MW'(ua);
  assign p_00 = MW'(u0) * MW'(u0);
  assign p_ff = MW'(uf) * MW'(uf);
  assign p_mm = MW'(um) * MW'(um);
  assign p_am = MW'(ua) * MW'(um);

  logic             s1_v_r;
  mttp_pkg::ctx_t   s1_ctx_r;
  mttp_pkg::dword_t s1_s0_r, s1_sf_r, s1_sm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= s0_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctx_r.status <= lim_err ? mttp_pkg::ST_VLIM :
                         np_err  ? mttp_pkg::ST_NONPOS : mttp_pkg::ST_OK;
      s1_ctx_r.kind   <= mttp_pkg::KIND_NONE;
      s1_ctx_r.u0     <= u0;
      s1_ctx_r.uf     <= uf;
      s1_ctx_r.um     <= um;
      s1_ctx_r.ua     <= ua;
      s1_ctx_r.vel    <= '0;
      s1_ctx_r.twoda  <= PW'({p_da, 1'b0});
      s1_ctx_r.need   <= '0;
      s1_ctx_r.den3   <= PW'({p_am, 1'b0});
      s1_s0_r         <= PW'(p_00);
      s1_sf_r         <= PW'(p_ff);
      s1_sm_r         <= PW'(p_mm);
    end
  end

  // stage 2: feasibility and profile choice
  mttp_pkg::dword_t diff, need, sq_in;
  logic [1:0]       st2, kind2;
  mttp_pkg::ctx_t   ctx2;

  assign diff  = (s1_s0_r > s1_sf_r) ? s1_s0_r - s1_sf_r : s1_sf_r - s1_s0_r;
  assign need  = (s1_sm_r << 1) - s1_s0_r - s1_sf_r;
  assign sq_in = (s1_ctx_r.twoda + s1_s0_r + s1_sf_r) >> 1;

  always_comb begin
    st2   = s1_ctx_r.status;
    kind2 = mttp_pkg::KIND_NONE;
    if (st2 == mttp_pkg::ST_OK) begin
      if (s1_ctx_r.twoda < diff) st2 = mttp_pkg::ST_IMPOSS;
      else if (s1_ctx_r.twoda < need) kind2 = mttp_pkg::KIND_PEAK;
      else kind2 = mttp_pkg::KIND_CRUISE;
    end
  end

  always_comb begin
    ctx2        = s1_ctx_r;
    ctx2.status = st2;
    ctx2.kind   = kind2;
    ctx2.need   = need;
  end

  // square root pipeline, entry 0 is the stage 2 register
  logic             sq_v_r    [0:SQ];
  mttp_pkg::ctx_t   sq_ctx_r  [0:SQ];
  mttp_pkg::dword_t sq_n_r    [0:SQ];
  mttp_pkg::dword_t sq_root_r [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_ctx_r[0]  <= ctx2;
      sq_n_r[0]    <= sq_in;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam mttp_pkg::dword_t BIT = PW'(1) << (PW - 2 - 2 * k);
    mttp_pkg::dword_t t;
    logic             ge;
    assign t  = sq_root_r[k] + BIT;
    assign ge = sq_n_r[k] >= t;
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_ctx_r[k+1]  <= sq_ctx_r[k];
        sq_n_r[k+1]    <= ge ? sq_n_r[k] - t : sq_n_r[k];
        sq_root_r[k+1] <= ge ? (sq_root_r[k] >> 1) + BIT : sq_root_r[k] >> 1;
      end
    end
  end

  // operand select, entry 0 of the divider context line
  mttp_pkg::mag_t   vp, top_v;
  logic             is_peak;
  logic             dv_v_r   [0:DL];
  mttp_pkg::ctx_t   dv_ctx_r [0:DL];
  mttp_pkg::ctx_t   dv_ctx_in;
  mttp_pkg::dword_t num1_r, num2_r, num3_r;

  assign vp      = sq_root_r[SQ][VW-2:0];
  assign is_peak = sq_ctx_r[SQ].kind == mttp_pkg::KIND_PEAK;
  assign top_v   = is_peak ? vp : sq_ctx_r[SQ].um;

  always_comb begin
    dv_ctx_in     = sq_ctx_r[SQ];
    dv_ctx_in.vel = (sq_ctx_r[SQ].kind == mttp_pkg::KIND_NONE) ? '0 : top_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sq_v_r[SQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ctx_r[0] <= dv_ctx_in;
      num1_r <= PW'(top_v - sq_ctx_r[SQ].u0);
      num2_r <= PW'(top_v - sq_ctx_r[SQ].uf);
      num3_r <= sq_ctx_r[SQ].twoda - sq_ctx_r[SQ].need;
    end
  end

  for (genvar k = 0; k < DL; k++) begin : g_dctx
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (en) dv_v_r[k+1] <= dv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) dv_ctx_r[k+1] <= dv_ctx_r[k];
    end
  end

  mttp_pkg::word_t q1, q2, q3;

  mttp_fixdiv u_div_acc (
    .clk (clk), .en (en), .num (num1_r), .den (PW'(dv_ctx_r[0].ua)), .quo (q1)
  );
  mttp_fixdiv u_div_dec (
    .clk (clk), .en (en), .num (num2_r), .den (PW'(dv_ctx_r[0].ua)), .quo (q2)
  );
  mttp_fixdiv u_div_cru (
    .clk (clk), .en (en), .num (num3_r), .den (dv_ctx_r[0].den3), .quo (q3)
  );

  // accel end and decel start
  logic [VW:0]     sum13;
  logic            sm_v_r;
  mttp_pkg::ctx_t  sm_ctx_r;
  mttp_pkg::word_t sm_t1_r, sm_t2_r, sm_q2_r;

  assign sum13 = {1'b0, q1} + {1'b0, q3};

  always_ff @(posedge clk) begin
    if (!rst_n) sm_v_r <= 1'b0;
    else if (en) sm_v_r <= dv_v_r[DL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_ctx_r <= dv_ctx_r[DL];
      sm_t1_r  <= q1;
      sm_t2_r  <= (dv_ctx_r[DL].kind == mttp_pkg::KIND_PEAK) ? q1 :
                  (sum13[VW] ? '1 : sum13[VW-1:0]);
      sm_q2_r  <= q2;
    end
  end

  // output register
  logic [VW:0]     sum_end;
  logic            ok;
  logic [1:0]      status_r, kind_r;
  mttp_pkg::word_t t1_r, t2_r, t3_r;
  mttp_pkg::mag_t  vel_r;

  assign sum_end = {1'b0, sm_t2_r} + {1'b0, sm_q2_r};
  assign ok      = sm_ctx_r.status == mttp_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= sm_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= sm_ctx_r.status;
      kind_r   <= ok ? sm_ctx_r.kind : mttp_pkg::KIND_NONE;
      t1_r     <= ok ? sm_t1_r : '0;
      t2_r     <= ok ? sm_t2_r : '0;
      t3_r     <= ok ? (sum_end[VW] ? '1 : sum_end[VW-1:0]) : '0;
      vel_r    <= ok ? sm_ctx_r.vel : '0;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = status_r;
  assign out_if.profile_kind     = kind_r;
  assign out_if.time_accel_end   = t1_r;
  assign out_if.time_decel_start = t2_r;
  assign out_if.time_move_end    = t3_r;
  assign out_if.profile_velocity = vel_r;

  `MTTP_ASSERT_IMPL(a_err_zero, out_valid_r && status_r != mttp_pkg::ST_OK,
    kind_r == mttp_pkg::KIND_NONE && t3_r == '0 && vel_r == '0, "error item not zeroed")
  `MTTP_ASSERT_IMPL(a_ok_kind, out_valid_r && status_r == mttp_pkg::ST_OK,
    kind_r == mttp_pkg::KIND_PEAK || kind_r == mttp_pkg::KIND_CRUISE, "ok item without profile")
  `MTTP_ASSERT_IMPL(a_time_order, out_valid_r && status_r == mttp_pkg::ST_OK,
    t1_r <= t2_r && t2_r <= t3_r, "breakpoint times out of order")
  `MTTP_ASSERT_IMPL(a_peak_no_cruise, out_valid_r && kind_r == mttp_pkg::KIND_PEAK,
    t1_r == t2_r, "peak profile with cruise time")
  `MTTP_ASSERT_NEXT(a_pipe_advance, en && sm_v_r, out_valid_r, "item lost at output stage")

endmodule

// ===== verif/tb_chan_if.sv =====
// testbench item types of the trapezoid profile core: move request and result
// depends on mttp_pkg
package tb_trap_pkg;

  typedef struct packed {
    logic [1:0]      status;
    logic [1:0]      kind;
    mttp_pkg::word_t t1;
    mttp_pkg::word_t t2;
    mttp_pkg::word_t t3;
    mttp_pkg::mag_t  vel;
  } move_result_t;

  typedef struct packed {
    mttp_pkg::word_t distance;
    mttp_pkg::word_t v0;
    mttp_pkg::word_t vf;
  } move_req_t;
endpackage

// ===== verif/tb.sv =====
// self-checking testbench of min_time_trapezoid_profile_core
// drives move requests and register writes, predicts each result and compares it
// depends on mttp_pkg, tb_trap_pkg and the three channel interfaces
module tb;

  localparam int LAT = 3 + mttp_pkg::SQ_STEPS + 1 + mttp_pkg::DIV_LAT + 2;
  localparam logic [63:0] TMAX = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  mttp_in_if  in_ch ();
  mttp_out_if out_ch ();
  mttp_cfg_if cfg_ch ();

  min_time_trapezoid_profile_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  mttp_pkg::word_t vfloor, vceil, arate;
  tb_trap_pkg::move_result_t pending_results[$];
  int errors = 0;
  int n_moves = 0;
  int n_results = 0;
  int n_peak = 0, n_cruise = 0, n_err = 0;
  int stall_mode = 0;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] qdiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < mttp_pkg::FB; i++) begin
      if (q > TMAX) return TMAX;
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q[0] = 1'b1;
      end else begin
        r = r << 1;
      end
    end
    return (q > TMAX) ? TMAX : q;
  endfunction

  function automatic logic [63:0] tsum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a || s > TMAX) ? TMAX : s;
  endfunction

  function automatic tb_trap_pkg::move_result_t plan_move(tb_trap_pkg::move_req_t rq);
    tb_trap_pkg::move_result_t r;
    longint d, v0, vf, lo, hi, a;
    logic [63:0] ud, ua, u0, uf, um, s0, sf, sm, twoda, diff, need, vp;
    r = '0;
    d = longint'(signed'(rq.distance));
    v0 = longint'(signed'(rq.v0));
    vf = longint'(signed'(rq.vf));
    lo = longint'(signed'(vfloor));
    hi = longint'(signed'(vceil));
    a = longint'(signed'(arate));
    if (lo < 0 || hi <= lo || v0 < lo || v0 > hi || vf < lo || vf > hi) begin
      r.status = mttp_pkg::ST_VLIM;
    end else if (d <= 0 || a <= 0) begin
      r.status = mttp_pkg::ST_NONPOS;
    end else begin
      ud = d; ua = a; u0 = v0; uf = vf; um = hi;
      s0 = u0 * u0; sf = uf * uf; sm = um * um;
      twoda = 2 * ud * ua;
      diff = (s0 > sf) ? s0 - sf : sf - s0;
      need = 2 * sm - s0 - sf;
      if (twoda < diff) begin
        r.status = mttp_pkg::ST_IMPOSS;
      end else if (twoda < need) begin
        vp = isqrt((twoda + s0 + sf) >> 1);
        r.status = mttp_pkg::ST_OK;
        r.kind = mttp_pkg::KIND_PEAK;
        r.t1 = mttp_pkg::word_t'(qdiv(vp - u0, ua));
        r.t2 = r.t1;
        r.t3 = mttp_pkg::word_t'(tsum(r.t1, qdiv(vp - uf, ua)));
        r.vel = mttp_pkg::mag_t'(vp);
      end else begin
        r.status = mttp_pkg::ST_OK;
        r.kind = mttp_pkg::KIND_CRUISE;
        r.t1 = mttp_pkg::word_t'(qdiv(um - u0, ua));
        r.t2 = mttp_pkg::word_t'(tsum(r.t1, qdiv(twoda - need, 2 * ua * um)));
        r.t3 = mttp_pkg::word_t'(tsum(r.t2, qdiv(um - uf, ua)));
        r.vel = mttp_pkg::mag_t'(um);
      end
    end
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.distance = '0;
    in_ch.start_velocity = '0;
    in_ch.end_velocity = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mttp_pkg::REG_FLOOR;
    cfg_ch.data = '0;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && $urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
  end

  // result checker
  always @(posedge clk) begin
    tb_trap_pkg::move_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no pending move");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_ch.status); errors++;
        end
        if (out_ch.profile_kind !== exp_r.kind) begin
          $error("profile_kind exp %0d got %0d", exp_r.kind, out_ch.profile_kind); errors++;
        end
        if (out_ch.time_accel_end !== exp_r.t1) begin
          $error("time_accel_end exp %h got %h", exp_r.t1, out_ch.time_accel_end); errors++;
        end
        if (out_ch.time_decel_start !== exp_r.t2) begin
          $error("time_decel_start exp %h got %h", exp_r.t2, out_ch.time_decel_start);
          errors++;
        end
        if (out_ch.time_move_end !== exp_r.t3) begin
          $error("time_move_end exp %h got %h", exp_r.t3, out_ch.time_move_end); errors++;
        end
        if (out_ch.profile_velocity !== exp_r.vel) begin
          $error("profile_velocity exp %h got %h", exp_r.vel, out_ch.profile_velocity);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, mttp_pkg::word_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      mttp_pkg::REG_FLOOR: vfloor = val;
      mttp_pkg::REG_CEIL:  vceil = val;
      mttp_pkg::REG_ACCEL: arate = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(mttp_pkg::word_t lo, mttp_pkg::word_t hi, mttp_pkg::word_t a);
    write_reg(mttp_pkg::REG_FLOOR, lo);
    write_reg(mttp_pkg::REG_CEIL, hi);
    write_reg(mttp_pkg::REG_ACCEL, a);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // one move, its result predicted and queued for the checker
  task automatic send_move(tb_trap_pkg::move_req_t rq);
    tb_trap_pkg::move_result_t p;
    p = plan_move(rq);
    if (p.status == mttp_pkg::ST_OK && p.kind == mttp_pkg::KIND_PEAK) n_peak++;
    else if (p.status == mttp_pkg::ST_OK) n_cruise++;
    else n_err++;
    in_ch.valid <= 1'b1;
    in_ch.distance <= rq.distance;
    in_ch.start_velocity <= rq.v0;
    in_ch.end_velocity <= rq.vf;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(p);
    n_moves++;
  endtask

  task automatic gap();
    if ($urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic mttp_pkg::word_t rand_vel();
    longint lo, hi, span;
    lo = longint'(signed'(vfloor));
    hi = longint'(signed'(vceil));
    span = hi - lo;
    case ($urandom_range(0, 9))
      0: return vfloor;
      1: return vceil;
      2: return $urandom;
      default: begin
        if (span <= 0) return $urandom;
        return mttp_pkg::word_t'(lo + longint'({$urandom, $urandom} % (span + 1)));
      end
    endcase
  endfunction

  function automatic mttp_pkg::word_t rand_dist();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return mttp_pkg::word_t'(32'h7FFF_FFFF);
      2: return mttp_pkg::word_t'($urandom_range(0, 3));
      3: return mttp_pkg::word_t'($urandom_range(1, 32'h0000_FFFF));
      default: return mttp_pkg::word_t'($urandom_range(1, 32'h00FF_FFFF));
    endcase
  endfunction

  typedef struct {
    tb_trap_pkg::move_req_t    rq;
    bit                        typed;
    tb_trap_pkg::move_result_t res;
  } dir_row_t;

  dir_row_t rows[$];

  initial begin
    tb_trap_pkg::move_req_t rq;
    tb_trap_pkg::move_result_t zr;
    vfloor = '0; vceil = 32'd65536; arate = 32'd65536;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zr = '0;
    // reset settings: floor 0, ceiling 1.0, accel 1.0
    rows.push_back('{'{32'h0001_0000, 32'h0, 32'h0}, 0, zr});
    zr.status = mttp_pkg::ST_VLIM;
    rows.push_back('{'{32'h0001_0000, 32'hFFFF_FFFF, 32'h0}, 1, zr});
    rows.push_back('{'{32'h0001_0000, 32'h0, 32'h0001_0001}, 1, zr});
    rows.push_back('{'{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 1, zr});
    zr.status = mttp_pkg::ST_NONPOS;
    rows.push_back('{'{32'h0, 32'h0, 32'h0}, 1, zr});
    rows.push_back('{'{32'h8000_0000, 32'h0001_0000, 32'h0}, 1, zr});
    zr.status = mttp_pkg::ST_IMPOSS;
    rows.push_back('{'{32'h0000_0001, 32'h0001_0000, 32'h0}, 1, zr});
    rows.push_back('{'{32'h0000_0001, 32'h0, 32'h0001_0000}, 1, zr});
    rows.push_back('{'{32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000}, 0, zr});
    rows.push_back('{'{32'h0000_8000, 32'h0, 32'h0}, 0, zr});
    rows.push_back('{'{32'h0000_0001, 32'h0, 32'h0}, 0, zr});
    rows.push_back('{'{32'h0001_0000, 32'h0001_0000, 32'h0}, 0, zr});
    foreach (rows[i]) begin
      if (rows[i].typed && plan_move(rows[i].rq) != rows[i].res) begin
        $error("directed row %0d disagrees with predictor", i); errors++;
      end
      send_move(rows[i].rq);
    end
    in_ch.valid <= 1'b0;
    drain();

    // extreme settings
    set_limits(32'h0, 32'h7FFF_FFFF, 32'h0000_0001);
    rq = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0}; send_move(rq);
    rq = '{32'h7FFF_FFFF, 32'h0, 32'h0}; send_move(rq);
    rq = '{32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; send_move(rq);
    in_ch.valid <= 1'b0;
    drain();
    set_limits(32'h0000_1000, 32'h0000_1000, 32'h8000_0000);
    rq = '{32'h0001_0000, 32'h0000_1000, 32'h0000_1000}; send_move(rq);
    in_ch.valid <= 1'b0;
    drain();
    set_limits(32'h8000_0000, 32'h0001_0000, 32'h0);
    rq = '{32'h0001_0000, 32'h0, 32'h0}; send_move(rq);
    in_ch.valid <= 1'b0;
    drain();
    set_limits(32'h0, 32'h0002_0000, 32'h0);
    rq = '{32'h0001_0000, 32'h0, 32'h0}; send_move(rq);
    rq = '{32'h0001_0000, 32'hFFFF_0000, 32'h0}; send_move(rq);
    in_ch.valid <= 1'b0;
    drain();

    // random phases, each opening with one of seven register settings
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: set_limits(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        1: set_limits(32'h0, 32'h0001_0000, 32'h0001_0000);
        2: set_limits($urandom_range(0, 32'h0001_0000), $urandom_range(32'h0002_0000,
                      32'h7FFF_FFFF), $urandom_range(1, 32'h00FF_FFFF));
        3: set_limits(32'h0, 32'h0000_0100, 32'h0000_0001);
        4: set_limits($urandom, $urandom, $urandom);
        5: set_limits(32'h0000_8000, 32'h0010_0000, $urandom_range(1, 32'h0000_FFFF));
        default: set_limits(32'h0, $urandom_range(1, 32'h7FFF_FFFF), $urandom);
      endcase
      for (int k = 0; k < 75; k++) begin
        rq.distance = rand_dist();
        rq.v0 = rand_vel();
        rq.vf = rand_vel();
        send_move(rq);
        gap();
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("moves %0d, results %0d: peak %0d, cruise %0d, rejected %0d",
             n_moves, n_results, n_peak, n_cruise, n_err);
    $display("register settings covered reset, extremes and random limits");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end
endmodule
